// File: rtl/assert_macros.svh
// Assertion macros used by the reassembler datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`endif

// File: rtl/bsr_pkg.sv
// Types and constants shared by the byte stream reassembler modules.
package bsr_pkg;

  localparam int CFG_W = 13;
  localparam int CNT_W = 13;
  localparam logic [CFG_W-1:0] CAP_RESET = 13'd4096;

  typedef struct packed {
    logic        func;
    logic [31:0] stream_index;
    logic [7:0]  byte_value;
    logic        has_byte;
    logic        eof_mark;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       pop_byte;
    logic             pop_valid;
    logic [31:0]      assembled_point;
    logic [CNT_W-1:0] pending_count;
    logic [CNT_W-1:0] readable_count;
    logic             input_ended;
  } out_item_t;

  localparam logic FUNC_SEGMENT = 1'b0;
  localparam logic FUNC_POP     = 1'b1;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic ins_rd;
    logic ins_ck;
    logic scan_rd;
    logic scan_ck;
    logic pop_rd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic func;
    logic has_byte;
    logic vbit;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/bsr_ctrl.sv
// Sequencer for the reassembler: clear pass, insert, advance scan, pop and result.
module bsr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bsr_pkg::stat_t stat,
  output bsr_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    CLEAR, IDLE, INS_RD, INS_CK, SCAN_RD, SCAN_CK, POP_RD, EMIT
  } state_t;

  state_t state;

  assign in_stall = (state != IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == IDLE) && in_valid;
    cmd.clr_step = (state == CLEAR);
    cmd.ins_rd   = (state == INS_RD);
    cmd.ins_ck   = (state == INS_CK);
    cmd.scan_rd  = (state == SCAN_RD);
    cmd.scan_ck  = (state == SCAN_CK);
    cmd.pop_rd   = (state == POP_RD);
    cmd.emit     = (state == EMIT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
    end else begin
      unique case (state)
        CLEAR:   if (stat.clr_last) state <= IDLE;
        IDLE: begin
          if (in_valid) state <= INS_RD;
        end
        // The item fields are not registered yet in IDLE, so the branch is taken in INS_RD, once they are.
        INS_RD: begin
          priority if (stat.func == bsr_pkg::FUNC_POP) state <= POP_RD;
          else if (!stat.has_byte) state <= EMIT;
          else state <= INS_CK;
        end
        INS_CK:  state <= SCAN_RD;
        SCAN_RD: state <= SCAN_CK;
        SCAN_CK: state <= stat.vbit ? SCAN_RD : EMIT;
        POP_RD:  state <= EMIT;
        EMIT:    if (stat.out_free) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: rtl/bsr_dp.sv
// Datapath of the reassembler: indices, valid-bit and byte memories, result register.
`include "assert_macros.svh"

module bsr_dp #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bsr_pkg::CFG_W-1:0] cfg_data,
  input  bsr_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bsr_pkg::out_item_t        out_data,
  input  bsr_pkg::cmd_t             cmd,
  output bsr_pkg::stat_t            stat
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic [bsr_pkg::CFG_W-1:0] cap_reg;
  bsr_pkg::in_item_t         item;
  logic [31:0]               asm_idx;
  logic [31:0]               rd_idx;
  logic [31:0]               end_idx;
  logic                      end_seen;
  logic [bsr_pkg::CNT_W-1:0] pending;
  logic [AW-1:0]             clr_cnt;
  logic                      hit;
  logic                      popped;
  logic                      vbit;
  logic [7:0]                ring_q;

  logic                      vmem [STORE_DEPTH];
  logic [7:0]                ring [STORE_DEPTH];

  logic [31:0] cap_eff;
  logic [31:0] held;
  logic [31:0] space;
  logic [31:0] off;
  logic [AW-1:0] ins_slot;
  logic [AW-1:0] asm_slot;
  logic        ins_wr;
  logic        avail;

  assign ins_slot = item.stream_index[AW-1:0];
  assign asm_slot = asm_idx[AW-1:0];
  assign cap_eff  = (32'(cap_reg) > 32'(STORE_DEPTH)) ? 32'(STORE_DEPTH) : 32'(cap_reg);
  assign held     = asm_idx - rd_idx;
  assign space    = (held >= cap_eff) ? 32'd0 : cap_eff - held;
  assign off      = item.stream_index - asm_idx;
  assign ins_wr   = cmd.ins_ck && hit && !vbit;
  assign avail    = (asm_idx != rd_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= bsr_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_reg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
    if (cmd.ins_rd) hit <= (off < space);
  end

  // Valid-bit memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      vmem[clr_cnt] <= 1'b0;
    end else if (ins_wr) begin
      vmem[ins_slot] <= 1'b1;
    end else if (cmd.scan_ck && vbit) begin
      vmem[asm_slot] <= 1'b0;
    end
    if (cmd.ins_rd) begin
      vbit <= vmem[ins_slot];
    end else if (cmd.scan_rd) begin
      vbit <= vmem[asm_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (ins_wr) ring[ins_slot] <= item.byte_value;
    if (cmd.pop_rd) ring_q <= ring[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      asm_idx  <= '0;
      rd_idx   <= '0;
      end_idx  <= '0;
      end_seen <= 1'b0;
      pending  <= '0;
      popped   <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.load && in_data.func == bsr_pkg::FUNC_SEGMENT && in_data.eof_mark) begin
        end_seen <= 1'b1;
        end_idx  <= in_data.stream_index + 32'(in_data.has_byte);
      end
      if (cmd.load) popped <= 1'b0;
      if (cmd.pop_rd && avail) begin
        popped <= 1'b1;
        rd_idx <= rd_idx + 32'd1;
      end
      if (ins_wr) begin
        pending <= pending + 1'b1;
      end else if (cmd.scan_ck && vbit) begin
        asm_idx <= asm_idx + 32'd1;
        if (pending != '0) pending <= pending - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.pop_byte        <= popped ? ring_q : 8'd0;
      out_data.pop_valid       <= popped;
      out_data.assembled_point <= asm_idx;
      out_data.pending_count   <= pending;
      out_data.readable_count  <= held[bsr_pkg::CNT_W-1:0];
      out_data.input_ended     <= end_seen && (end_idx == asm_idx);
    end
  end

  always_comb begin
    stat          = '0;
    stat.clr_last = cmd.clr_step && (clr_cnt == {AW{1'b1}});
    stat.func     = item.func;
    stat.has_byte = item.has_byte;
    stat.vbit     = vbit;
    stat.out_free = !out_valid || !out_stall;
  end

  `ASSERT_CLK(a_held_fits, held <= 32'(STORE_DEPTH), "assembled bytes exceed store depth")
  `ASSERT_CLK(a_emit_free, !cmd.emit || !out_valid || !out_stall, "result overwrote a stalled transfer")
  `ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid, "result register not loaded after emit")

endmodule

// File: rtl/byte_stream_reassembler.sv
// Top level of the byte stream reassembler.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------
//  config   | cfg_we               | cfg_data (window capacity)
//  input    | in_valid / in_stall  | in_data (bsr_pkg::in_item_t)
//  output   | out_valid / out_stall| out_data (bsr_pkg::out_item_t)
//
// After reset a clearing pass empties the valid bits; no input transfer is taken
// meanwhile. A segment byte reads and checks its valid bit, then the scan reads and
// checks one valid bit for each byte the assembled point moves. A pop reads the ring
// and an empty segment goes to its result. A stalled output holds its result while
// the next item is taken and worked on; only its result waits for the output register.
module byte_stream_reassembler #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bsr_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bsr_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bsr_pkg::out_item_t        out_data
);

  bsr_pkg::cmd_t  cmd;
  bsr_pkg::stat_t stat;

  bsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsr_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
